// ===== hdl/rsmwm_pkg.sv =====
// package for the masked raster store with window mean
// holds field widths, raster limits, codes and the sequencer state type
// no dependencies
package rsmwm_pkg;

	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_HALF   = 15;

	localparam int DIM_W   = 10;
	localparam int X_W     = $clog2(MAX_WIDTH);
	localparam int Y_W     = $clog2(MAX_HEIGHT);
	localparam int ADDR_W  = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int HALF_W  = 4;
	localparam int SMP_W   = 16;
	localparam int MEAN_W  = 24;
	localparam int CNT_W   = 10;
	localparam int FRAC_W  = 8;
	localparam int SUM_W   = 26;
	localparam int DIV_W   = SUM_W - 1 + FRAC_W;
	localparam int DCNT_W  = $clog2(DIV_W);

	localparam logic [SMP_W-1:0] NODATA_CODE = 16'h8181;
	localparam logic signed [SMP_W-1:0] NODATA_LIMIT = -16'sd10000;
	localparam logic signed [MEAN_W-1:0] NODATA_MEAN = -24'sd2560000;

	// request kinds
	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_READ   = 2'd1;
	localparam logic [1:0] FN_WINDOW = 2'd2;
	localparam logic [1:0] FN_NONE   = 2'd3;

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_WRITE,
		ST_PREAD,
		ST_PWAIT,
		ST_SCAN,
		ST_DRAIN,
		ST_DSTART,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/raster_store_masked_window_mean_unit.sv =====
// Raster store with no-data masking, point access and a box-window mean.
// After reset the block sweeps the 262144-entry sample memory once, one entry a cycle,
// writing the no-data code; no request is taken during that sweep, configuration
// writes are. Requests are then handled one at a time. A window mean reads every
// cell of the clipped window (up to 961 cells) through the single memory read port,
// one cell a cycle, then a bit-serial divider computes sum*256/count. The next
// request is taken while a result still waits.
// depends on rsmwm_pkg
module raster_store_masked_window_mean_unit
	import rsmwm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_index[8:0], y_index[17:9], write_value[33:18], half_x[37:34], half_y[41:38], zero pad
	input  logic [47:0] s_axis_tdata,
	// func[1:0]
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// point_value[15:0], mean_value[39:16], valid_count[49:40], zero pad
	output logic [55:0] m_axis_tdata,
	// status[0], has_data[1]
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	state_t state_q, state_d;

	logic [DIM_W-1:0] raster_width_q, raster_height_q;
	logic [DIM_W-1:0] w_eff, h_eff;

	logic [1:0]        func_q;
	logic [X_W-1:0]    x_q;
	logic [Y_W-1:0]    y_q;
	logic [SMP_W-1:0]  wv_q;
	logic [HALF_W-1:0] hx_q, hy_q;

	logic           window_q;
	logic [X_W-1:0] x0_q, x1_q, ix_q;
	logic [Y_W-1:0] y0_q, y1_q, iy_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic rd_pend_s1;

	logic [DIV_W-1:0]  divq_q;
	logic [CNT_W-1:0]  rem_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic              neg_q;

	logic             res_status_q, res_has_q;
	logic [SMP_W-1:0] res_pv_q;
	logic [MEAN_W-1:0] res_mean_q;
	logic [CNT_W-1:0] res_cnt_q;

	logic             out_valid_q, out_status_q, out_has_q;
	logic [SMP_W-1:0] out_pv_q;
	logic [MEAN_W-1:0] out_mean_q;
	logic [CNT_W-1:0] out_cnt_q;

	logic [SMP_W-1:0] mem [2**ADDR_W];
	logic [SMP_W-1:0] mem_rdata_q;
	logic             mem_we;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [SMP_W-1:0] mem_wdata;

	logic in_fire, out_load;

	// decode helpers
	logic oob, point_req, last_col, last_row;
	logic [X_W-1:0] x0_c, x1_c;
	logic [Y_W-1:0] y0_c, y1_c;
	logic [DIM_W-1:0] xs_c, ys_c;
	logic [Y_W-1:0] ysel;
	logic [X_W+DIM_W-1:0] prod;
	logic signed [SMP_W-1:0] rd_val;
	logic rd_ok;
	logic [CNT_W:0] trial;
	logic [SUM_W-1:0] sum_mag;
	logic [MEAN_W-1:0] q_mag;

	assign w_eff = (raster_width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : raster_width_q;
	assign h_eff = (raster_height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : raster_height_q;

	assign oob = ({1'b0, x_q} >= w_eff) || ({1'b0, y_q} >= h_eff);
	assign point_req = (func_q == FN_READ) || (hx_q < HALF_W'(2) && hy_q < HALF_W'(2));

	// window clipped at the raster edges
	assign x0_c = (x_q < X_W'(hx_q)) ? '0 : x_q - X_W'(hx_q);
	assign y0_c = (y_q < Y_W'(hy_q)) ? '0 : y_q - Y_W'(hy_q);
	assign xs_c = DIM_W'(x_q) + DIM_W'(hx_q);
	assign ys_c = DIM_W'(y_q) + DIM_W'(hy_q);
	assign x1_c = (xs_c >= w_eff) ? X_W'(w_eff - 1'b1) : xs_c[X_W-1:0];
	assign y1_c = (ys_c >= h_eff) ? Y_W'(h_eff - 1'b1) : ys_c[Y_W-1:0];

	assign ysel = window_q ? y0_q : y_q;
	assign prod = ysel * w_eff;

	assign last_col = (ix_q == x1_q);
	assign last_row = (iy_q == y1_q);

	assign rd_val = $signed(mem_rdata_q);
	assign rd_ok  = rd_val > NODATA_LIMIT;

	assign trial   = {rem_q, divq_q[DIV_W-1]};
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign q_mag   = divq_q[MEAN_W-1:0];

	assign in_fire = s_axis_tvalid && s_axis_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == '1) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (s_axis_tvalid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (func_q == FN_NONE || oob) state_d = ST_DONE;
				else state_d = ST_MUL;
			end
			ST_MUL: begin
				if (func_q == FN_WRITE) state_d = ST_WRITE;
				else if (window_q) state_d = ST_SCAN;
				else state_d = ST_PREAD;
			end
			ST_WRITE:  state_d = ST_DONE;
			ST_PREAD:  state_d = ST_PWAIT;
			ST_PWAIT:  state_d = ST_DONE;
			ST_SCAN: begin
				if (last_col && last_row) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_DSTART;
			ST_DSTART: begin
				if (cnt_q == '0) state_d = ST_DONE;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (dcnt_q == '0) state_d = ST_FIN;
			end
			ST_FIN:    state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || m_axis_tready) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = row_base_q + ADDR_W'(x_q);
		mem_wdata     = wv_q;
		mem_raddr     = row_base_q + ADDR_W'(x_q);
		out_load      = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = NODATA_CODE;
			end
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_WRITE: mem_we = 1'b1;
			ST_SCAN:  mem_raddr = row_base_q + ADDR_W'(ix_q);
			ST_DONE:  out_load = !out_valid_q || m_axis_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raster_width_q  <= '0;
			raster_height_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  raster_width_q  <= cfg_data;
				REG_HEIGHT: raster_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sample memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR) clr_addr_q <= clr_addr_q + 1'b1;
			rd_pend_s1 <= (state_q == ST_SCAN);
		end
	end

	// accumulate the cell read in the previous cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (state_q == ST_MUL) begin
			sum_q <= '0;
			cnt_q <= '0;
		end else if (rd_pend_s1 && rd_ok) begin
			sum_q <= sum_q + SUM_W'(rd_val);
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// request fields and sequencer datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= s_axis_tuser;
			x_q    <= s_axis_tdata[8:0];
			y_q    <= s_axis_tdata[17:9];
			wv_q   <= s_axis_tdata[33:18];
			hx_q   <= s_axis_tdata[37:34];
			hy_q   <= s_axis_tdata[41:38];
		end

		case (state_q)
			ST_DECODE: begin
				window_q     <= (func_q == FN_WINDOW) && !point_req;
				x0_q         <= x0_c;
				x1_q         <= x1_c;
				y0_q         <= y0_c;
				y1_q         <= y1_c;
				res_status_q <= oob && (func_q != FN_NONE);
				res_has_q    <= 1'b0;
				res_pv_q     <= '0;
				res_mean_q   <= '0;
				res_cnt_q    <= '0;
			end
			ST_MUL: begin
				row_base_q <= prod[ADDR_W-1:0];
				ix_q       <= x0_q;
				iy_q       <= y0_q;
			end
			ST_SCAN: begin
				if (last_col) begin
					ix_q <= x0_q;
					if (!last_row) begin
						iy_q       <= iy_q + 1'b1;
						row_base_q <= row_base_q + ADDR_W'(w_eff);
					end
				end else begin
					ix_q <= ix_q + 1'b1;
				end
			end
			ST_PWAIT: begin
				res_pv_q   <= rd_ok ? mem_rdata_q : NODATA_LIMIT;
				res_mean_q <= rd_ok ? {mem_rdata_q, {FRAC_W{1'b0}}}
					: {NODATA_LIMIT, {FRAC_W{1'b0}}};
				res_cnt_q  <= CNT_W'(rd_ok);
				res_has_q  <= rd_ok;
			end
			ST_DSTART: begin
				divq_q     <= {sum_mag[SUM_W-2:0], {FRAC_W{1'b0}}};
				rem_q      <= '0;
				neg_q      <= sum_q[SUM_W-1];
				dcnt_q     <= DCNT_W'(DIV_W - 1);
				res_mean_q <= NODATA_MEAN;
			end
			ST_DIV: begin
				// restoring division, one quotient bit a cycle
				if (trial >= {1'b0, cnt_q}) begin
					rem_q  <= CNT_W'(trial - {1'b0, cnt_q});
					divq_q <= {divq_q[DIV_W-2:0], 1'b1};
				end else begin
					rem_q  <= trial[CNT_W-1:0];
					divq_q <= {divq_q[DIV_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_FIN: begin
				res_mean_q <= neg_q ? MEAN_W'(-q_mag) : q_mag;
				res_cnt_q  <= cnt_q;
				res_has_q  <= 1'b1;
			end
			default: begin
			end
		endcase

		if (out_load) begin
			out_status_q <= res_status_q;
			out_has_q    <= res_has_q;
			out_pv_q     <= res_pv_q;
			out_mean_q   <= res_mean_q;
			out_cnt_q    <= res_cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_cnt_q, out_mean_q, out_pv_q};
	assign m_axis_tuser  = {out_has_q, out_status_q};

	// checks
	a_pend_from_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q) == ST_SCAN)
		else $error("read pending without a scan cycle before");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q != '0)
		else $error("division by a zero count");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'((2 * MAX_HALF + 1) * (2 * MAX_HALF + 1)))
		else $error("valid count beyond the largest window");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result shown outside the done state");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN || state_q == ST_DIV) |-> !mem_we)
		else $error("memory written during a window mean");

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench for raster_store_masked_window_mean_unit: stream driver and
// monitor with random gaps, an in-bench raster predictor and a field-by-field checker
// depends on rsmwm_pkg and raster_store_masked_window_mean_unit
module tb_top;
	import rsmwm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4_000_000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [1:0]              func;
		logic [X_W-1:0]          x;
		logic [Y_W-1:0]          y;
		logic signed [SMP_W-1:0] value;
		logic [HALF_W-1:0]       half_x;
		logic [HALF_W-1:0]       half_y;
	} request_t;

	typedef struct packed {
		logic                     status;
		logic signed [SMP_W-1:0]  point;
		logic signed [MEAN_W-1:0] mean;
		logic [CNT_W-1:0]         count;
		logic                     has_data;
	} answer_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	// x_index, y_index, write_value, half_x, half_y, zero pad
	logic [47:0]       s_axis_tdata = '0;
	// func
	logic [1:0]        s_axis_tuser = '0;
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	// point_value, mean_value, valid_count, zero pad
	logic [55:0]       m_axis_tdata;
	// status, has_data
	logic [1:0]        m_axis_tuser;
	logic              cfg_we = 1'b0;
	logic              cfg_index = 1'b0;
	logic [DIM_W-1:0]  cfg_data = '0;

	// predictor state: mirror of the sample memory and the two dimension registers
	logic [SMP_W-1:0]  mirror_cells [MAX_WIDTH*MAX_HEIGHT];
	logic [DIM_W-1:0]  width_reg = '0;
	logic [DIM_W-1:0]  height_reg = '0;

	request_t          request_q [$];
	answer_t           answer_q [$];
	request_t          next_req;
	request_t          offered_req;
	answer_t           seen, want;
	logic              req_fire = 1'b0;
	int                reqs_queued = 0;
	int                results_done = 0;
	int                mismatches = 0;
	int                cycles = 0;
	bit                no_gaps = 1'b0;
	bit                hold_arm = 1'b0;
	bit                hold_used = 1'b0;
	int                hold_left = 0;

	raster_store_masked_window_mean_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic answer_t raster_response(request_t r);
		answer_t a;
		int w, h, xc, yc, hx, hy, x0, x1, y0, y1, v, cnt;
		longint sum;
		a = '0;
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		xc = int'(r.x);
		yc = int'(r.y);
		if (r.func == FN_NONE)
			return a;
		if (xc >= w || yc >= h) begin
			a.status = 1'b1;
			return a;
		end
		if (r.func == FN_WRITE) begin
			mirror_cells[yc * w + xc] = r.value;
			return a;
		end
		hx = (r.half_x > MAX_HALF) ? MAX_HALF : int'(r.half_x);
		hy = (r.half_y > MAX_HALF) ? MAX_HALF : int'(r.half_y);
		if (r.func == FN_READ || (hx < 2 && hy < 2)) begin
			v = $signed(mirror_cells[yc * w + xc]);
			if (v > NODATA_LIMIT) begin
				a.count = 1;
				a.has_data = 1'b1;
			end else begin
				v = NODATA_LIMIT;
			end
			a.point = 16'(v);
			a.mean = 24'(v * 256);
			return a;
		end
		// window clipped at the raster edges
		x0 = (xc < hx) ? 0 : xc - hx;
		y0 = (yc < hy) ? 0 : yc - hy;
		x1 = (xc + hx >= w) ? w - 1 : xc + hx;
		y1 = (yc + hy >= h) ? h - 1 : yc + hy;
		sum = 0;
		cnt = 0;
		for (int iy = y0; iy <= y1; iy++) begin
			for (int ix = x0; ix <= x1; ix++) begin
				v = $signed(mirror_cells[iy * w + ix]);
				if (v > NODATA_LIMIT) begin
					sum += v;
					cnt++;
				end
			end
		end
		if (cnt == 0) begin
			a.mean = NODATA_MEAN;
		end else begin
			// signed division truncates toward zero
			sum = (sum * 256) / cnt;
			a.mean = 24'(sum);
			a.count = 10'(cnt);
			a.has_data = 1'b1;
		end
		return a;
	endfunction

	function automatic request_t make_req(logic [1:0] f, int x, int y, int v, int hx, int hy);
		request_t r;
		r.func = f;
		r.x = X_W'(x);
		r.y = Y_W'(y);
		r.value = SMP_W'(v);
		r.half_x = HALF_W'(hx);
		r.half_y = HALF_W'(hy);
		return r;
	endfunction

	function automatic int pick_coord(int lo, int hi);
		if ($urandom_range(99) < 85)
			return $urandom_range(hi, lo);
		return $urandom_range(511);
	endfunction

	task automatic send(request_t r);
		request_q.push_back(r);
		reqs_queued++;
	endtask

	task automatic add_random(int n, int x_lo, int x_hi, int y_lo, int y_hi);
		int sel, v, hx, hy;
		logic [1:0] f;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 45)
				f = FN_WRITE;
			else if (sel < 65)
				f = FN_READ;
			else if (sel < 95)
				f = FN_WINDOW;
			else
				f = FN_NONE;
			sel = $urandom_range(99);
			if (sel < 50)
				v = int'($urandom_range(20000)) - 9999;
			else if (sel < 65)
				v = int'($urandom_range(4)) - 10002;
			else
				v = $urandom_range(16'hffff);
			if ($urandom_range(99) < 60) begin
				hx = $urandom_range(4);
				hy = $urandom_range(4);
			end else begin
				hx = $urandom_range(15);
				hy = $urandom_range(15);
			end
			send(make_req(f, pick_coord(x_lo, x_hi), pick_coord(y_lo, y_hi), v, hx, hy));
		end
	endtask

	// every request gives exactly one response
	task automatic drain_results();
		while (results_done != reqs_queued) begin
			@(posedge clk);
			#1;
		end
	endtask

	task automatic write_reg(logic idx, logic [DIM_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx == REG_WIDTH)
			width_reg = value;
		else
			height_reg = value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		#1;
	endtask

	task automatic set_raster(int w, int h);
		write_reg(REG_WIDTH, DIM_W'(w));
		write_reg(REG_HEIGHT, DIM_W'(h));
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			mismatches++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	// request driver
	always @(negedge clk) begin
		if (arst_n && (req_fire || !s_axis_tvalid)) begin
			if (request_q.size() == 0 || (!no_gaps && $urandom_range(99) < 36)) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				next_req = request_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata <= {6'd0, next_req.half_y, next_req.half_x, next_req.value,
					next_req.y, next_req.x};
				s_axis_tuser <= next_req.func;
				offered_req <= next_req;
			end
		end
	end

	// predict on every accepted request
	always @(posedge clk) begin
		req_fire <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			answer_q.push_back(raster_response(offered_req));
	end

	// response side ready, with one long hold-off
	always @(negedge clk) begin
		if (hold_arm && !hold_used) begin
			hold_used = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= no_gaps || ($urandom_range(99) >= 36);
		end
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			seen.status = m_axis_tuser[0];
			seen.has_data = m_axis_tuser[1];
			seen.point = m_axis_tdata[15:0];
			seen.mean = m_axis_tdata[39:16];
			seen.count = m_axis_tdata[49:40];
			if (answer_q.size() == 0) begin
				mismatches++;
				$display("%0t: response with nothing pending, expected none, actual %h",
					$time, seen);
			end else begin
				want = answer_q.pop_front();
				check_field("status", want.status, seen.status);
				check_field("point_value", want.point, seen.point);
				check_field("mean_value", want.mean, seen.mean);
				check_field("valid_count", want.count, seen.count);
				check_field("has_data", want.has_data, seen.has_data);
				results_done++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d responses of %0d", $time, results_done, reqs_queued);
			$display("** raster_store_masked_window_mean_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_WIDTH * MAX_HEIGHT; i++)
			mirror_cells[i] = NODATA_CODE;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		#1;

		// zero-size raster after reset: everything out of bounds, unused func stays quiet
		send(make_req(FN_READ, 0, 0, 0, 0, 0));
		send(make_req(FN_WINDOW, 5, 3, 0, 2, 2));
		send(make_req(FN_NONE, 511, 511, -1, 15, 15));
		drain_results();

		// oversized width register clamps to the full raster
		set_raster(1023, 512);
		send(make_req(FN_WRITE, 511, 511, 32767, 0, 0));
		send(make_req(FN_WRITE, 0, 0, -32768, 0, 0));
		send(make_req(FN_WRITE, 1, 0, -10000, 0, 0));
		send(make_req(FN_WRITE, 2, 0, -9999, 0, 0));
		send(make_req(FN_WRITE, 0, 1, 100, 0, 0));
		send(make_req(FN_WRITE, 1, 1, -7, 0, 0));
		send(make_req(FN_READ, 0, 0, 0, 0, 0));
		send(make_req(FN_READ, 1, 0, 0, 0, 0));
		send(make_req(FN_READ, 2, 0, 0, 15, 15));
		send(make_req(FN_READ, 511, 511, 0, 0, 0));
		send(make_req(FN_READ, 3, 3, 0, 0, 0));
		send(make_req(FN_WINDOW, 1, 1, 0, 2, 2));
		send(make_req(FN_WINDOW, 1, 1, 0, 1, 1));
		send(make_req(FN_WINDOW, 0, 0, 0, 0, 3));
		send(make_req(FN_WINDOW, 511, 511, 0, 15, 15));
		send(make_req(FN_WINDOW, 256, 256, 0, 15, 15));
		send(make_req(FN_WRITE, 3, 0, 1, 0, 0));
		send(make_req(FN_WRITE, 4, 0, 3, 0, 0));
		// mean that does not divide evenly, negative sum
		send(make_req(FN_WINDOW, 2, 0, 0, 2, 0));
		send(make_req(FN_NONE, 5, 5, 0, 0, 0));
		drain_results();

		set_raster(16, 16);
		add_random(140, 0, 15, 0, 15);
		drain_results();

		// long response stall while requests keep coming
		set_raster(20, 17);
		hold_arm = 1'b1;
		add_random(100, 0, 19, 0, 16);
		drain_results();

		// full raster, writes and windows around one spot
		set_raster(512, 512);
		add_random(40, 240, 270, 240, 270);
		drain_results();

		set_raster(0, 300);
		add_random(10, 0, 511, 0, 511);
		drain_results();
		set_raster(300, 0);
		add_random(8, 0, 511, 0, 511);
		drain_results();

		// back-to-back on both sides
		set_raster(37, 9);
		no_gaps = 1'b1;
		add_random(100, 0, 36, 0, 8);
		drain_results();
		no_gaps = 1'b0;

		set_raster(1, 512);
		add_random(30, 0, 0, 0, 511);
		drain_results();

		set_raster(700, 1023);
		add_random(20, 490, 511, 490, 511);
		drain_results();

		set_raster($urandom_range(40, 1), $urandom_range(40, 1));
		add_random(120, 0, 39, 0, 39);
		drain_results();

		// allow a stray response to show up
		repeat (1200) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) begin
			$display("** raster_store_masked_window_mean_unit: PASSED **");
		end else begin
			$display("** raster_store_masked_window_mean_unit: FAILED **");
		end
		$finish;
	end

endmodule
